[rtl/pil_pkg.sv]
// Shared types, widths and request/status codes for the positional insert list.
package pil_pkg;

  // List size and derived widths.
  localparam int CAPACITY = 16;
  localparam int IDX_W    = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int CNT_W    = $clog2(CAPACITY + 1);

  // Fixed field widths of the request and response items.
  localparam int TYPE_W   = 2;
  localparam int POS_W    = 5;
  localparam int DATA_W   = 32;
  localparam int STAT_W   = 2;
  localparam int COUNT_W  = 5;

  // Width used to compare a position against the entry count.
  localparam int CMP_W    = (POS_W > CNT_W) ? POS_W : CNT_W;

  typedef enum logic [TYPE_W-1:0] {
    REQ_APPEND = 2'd0,
    REQ_INSERT = 2'd1,
    REQ_PUT    = 2'd2,
    REQ_GET    = 2'd3
  } pil_req_t;

  typedef enum logic [STAT_W-1:0] {
    ST_OK     = 2'd0,
    ST_BADPOS = 2'd1,
    ST_FULL   = 2'd2
  } pil_status_t;

  typedef enum logic {
    S_IDLE = 1'b0,
    S_HOLD = 1'b1
  } pil_state_t;

  // Commands from the controller to the datapath and the channel handshakes.
  typedef struct packed {
    logic in_ready;
    logic out_valid;
    logic load;
  } pil_ctl_t;

endpackage

[rtl/pil_if.sv]
// Request and response channel interfaces of the positional insert list.
interface pil_req_if;
  logic                         valid;
  logic                         ready;
  logic [pil_pkg::TYPE_W-1:0]   req_type;
  logic [pil_pkg::POS_W-1:0]    position;
  logic signed [pil_pkg::DATA_W-1:0] value;

  modport source (output valid, output req_type, output position, output value,
                  input ready);
  modport sink   (input valid, input req_type, input position, input value,
                  output ready);
endinterface

interface pil_rsp_if;
  logic                         valid;
  logic                         ready;
  logic signed [pil_pkg::DATA_W-1:0] read_value;
  logic [pil_pkg::STAT_W-1:0]   status;
  logic [pil_pkg::COUNT_W-1:0]  entry_count;

  modport source (output valid, output read_value, output status,
                  output entry_count, input ready);
  modport sink   (input valid, input read_value, input status,
                  input entry_count, output ready);
endinterface

[rtl/positional_insert_list.sv]
// Top level of the positional insert list: controller plus datapath.
//
//   Channel  Dir  Fields                               Transfer when
//   req      in   req_type, position, value            req.valid && req.ready
//   rsp      out  read_value, status, entry_count      rsp.valid && rsp.ready
//
// Each request yields one response in the cycle after its transfer, held in an
// output register; a new request is taken in the cycle that response leaves,
// so one request per cycle is sustained when rsp.ready stays high.
// An insert shifts all later entries in the cell chain in that same cycle.
// Synchronous reset empties the list; entry contents are not cleared.
// A stalled response holds the block: req.ready drops until it transfers.
module positional_insert_list (
  input logic       clk,
  input logic       rst,
  pil_req_if.sink   req,
  pil_rsp_if.source rsp
);

  pil_pkg::pil_ctl_t ctl;

  pil_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (req.valid),
    .out_ready (rsp.ready),
    .ctl       (ctl)
  );

  pil_datapath u_datapath (
    .clk         (clk),
    .rst         (rst),
    .ctl         (ctl),
    .req_type    (req.req_type),
    .position    (req.position),
    .value       (req.value),
    .read_value  (rsp.read_value),
    .status      (rsp.status),
    .entry_count (rsp.entry_count)
  );

  assign req.ready = ctl.in_ready;
  assign rsp.valid = ctl.out_valid;

endmodule

[rtl/pil_ctrl.sv]
// Handshake controller: tracks whether a response is held for transfer.
module pil_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  input  logic              out_ready,
  output pil_pkg::pil_ctl_t ctl
);

  pil_pkg::pil_state_t state;
  pil_pkg::pil_state_t state_next;
  logic                accept;

  // A new request may enter when the response register is empty or is drained now.
  assign accept = in_valid && ((state == pil_pkg::S_IDLE) || out_ready);

  // Next-state logic.
  always_comb begin
    state_next = state;
    unique case (state)
      pil_pkg::S_IDLE: begin
        if (accept) state_next = pil_pkg::S_HOLD;
      end
      pil_pkg::S_HOLD: begin
        if (out_ready && !in_valid) state_next = pil_pkg::S_IDLE;
      end
      default: state_next = pil_pkg::S_IDLE;
    endcase
  end

  // Output logic.
  always_comb begin
    ctl = '0;
    unique case (state)
      pil_pkg::S_IDLE: begin
        ctl.in_ready  = 1'b1;
        ctl.out_valid = 1'b0;
      end
      pil_pkg::S_HOLD: begin
        ctl.in_ready  = out_ready;
        ctl.out_valid = 1'b1;
      end
      default: ctl = '0;
    endcase
    ctl.load = accept;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= pil_pkg::S_IDLE;
    end else begin
      state <= state_next;
    end
  end

endmodule

[rtl/pil_datapath.sv]
// Datapath: chain of entry cells, entry count and the response register.
module pil_datapath (
  input  logic                                clk,
  input  logic                                rst,
  input  pil_pkg::pil_ctl_t                   ctl,
  input  logic [pil_pkg::TYPE_W-1:0]          req_type,
  input  logic [pil_pkg::POS_W-1:0]           position,
  input  logic signed [pil_pkg::DATA_W-1:0]   value,
  output logic signed [pil_pkg::DATA_W-1:0]   read_value,
  output logic [pil_pkg::STAT_W-1:0]          status,
  output logic [pil_pkg::COUNT_W-1:0]         entry_count
);

  logic signed [pil_pkg::DATA_W-1:0] entries [pil_pkg::CAPACITY];
  logic [pil_pkg::CNT_W-1:0]         count;
  logic [pil_pkg::CNT_W-1:0]         count_next;

  logic [pil_pkg::CMP_W-1:0]         pos_ext;
  logic [pil_pkg::CMP_W-1:0]         cnt_ext;
  logic [pil_pkg::IDX_W-1:0]         pos_idx;
  logic                              pos_lt;
  logic                              pos_le;
  logic                              full;

  pil_pkg::pil_req_t                 kind;
  pil_pkg::pil_status_t              st;
  logic signed [pil_pkg::DATA_W-1:0] rd;
  logic                              do_write;
  logic                              do_shift;
  logic                              grow;
  logic [pil_pkg::IDX_W-1:0]         wr_idx;

  // Position checks against the current count.
  assign pos_ext = pil_pkg::CMP_W'(position);
  assign cnt_ext = pil_pkg::CMP_W'(count);
  assign pos_idx = position[pil_pkg::IDX_W-1:0];
  assign pos_lt  = pos_ext < cnt_ext;
  assign pos_le  = pos_ext <= cnt_ext;
  assign full    = count == pil_pkg::CNT_W'(pil_pkg::CAPACITY);
  assign kind    = pil_pkg::pil_req_t'(req_type);

  // Request decode: status, read data and the writes to the cell chain.
  always_comb begin
    st       = pil_pkg::ST_OK;
    rd       = '0;
    do_write = 1'b0;
    do_shift = 1'b0;
    grow     = 1'b0;
    wr_idx   = pos_idx;
    unique case (kind)
      pil_pkg::REQ_APPEND: begin
        wr_idx = count[pil_pkg::IDX_W-1:0];
        if (full) begin
          st = pil_pkg::ST_FULL;
        end else begin
          do_write = 1'b1;
          grow     = 1'b1;
        end
      end
      pil_pkg::REQ_INSERT: begin
        if (!pos_le) begin
          st = pil_pkg::ST_BADPOS;
        end else if (full) begin
          st = pil_pkg::ST_FULL;
        end else begin
          do_write = 1'b1;
          do_shift = 1'b1;
          grow     = 1'b1;
        end
      end
      pil_pkg::REQ_PUT: begin
        if (!pos_lt) begin
          st = pil_pkg::ST_BADPOS;
        end else begin
          do_write = 1'b1;
        end
      end
      pil_pkg::REQ_GET: begin
        if (!pos_lt) begin
          st = pil_pkg::ST_BADPOS;
        end else begin
          rd = entries[pos_idx];
        end
      end
      default: st = pil_pkg::ST_OK;
    endcase
  end

  assign count_next = grow ? count + pil_pkg::CNT_W'(1) : count;

  // Cell chain: each cell takes the new value or its lower neighbor on an insert.
  for (genvar i = 0; i < pil_pkg::CAPACITY; i++) begin : g_cell
    logic sel_write;
    logic sel_shift;

    assign sel_write = do_write && (wr_idx == pil_pkg::IDX_W'(i));
    if (i == 0) begin : g_first
      assign sel_shift = 1'b0;
    end else begin : g_rest
      assign sel_shift = do_shift && (pil_pkg::CMP_W'(i) > pos_ext)
                         && (pil_pkg::CMP_W'(i) <= cnt_ext);
    end

    always_ff @(posedge clk) begin
      if (ctl.load) begin
        if (sel_write) begin
          entries[i] <= value;
        end else if (sel_shift) begin
          entries[i] <= entries[(i > 0) ? i - 1 : 0];
        end
      end
    end
  end

  // Entry count.
  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else if (ctl.load) begin
      count <= count_next;
    end
  end

  // Response register, loaded with each accepted request.
  always_ff @(posedge clk) begin
    if (ctl.load) begin
      read_value  <= rd;
      status      <= st;
      entry_count <= pil_pkg::COUNT_W'(count_next);
    end
  end

endmodule
